FILE: rtl/aob_pkg.sv
// shared types and constants of the additive oscillator bank
// no dependencies
package aob_pkg;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_SAW    = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_DUP     = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_MISSING = 2'd3;

  // sine polynomial coefficients
  localparam logic [11:0] POLY_C3 = 12'd2383;
  localparam logic [14:0] POLY_C2 = 15'd21078;
  localparam logic [15:0] POLY_C1 = 16'd51471;
  localparam logic [16:0] HALF_TURN = 17'd32768;
  localparam logic [14:0] SINE_MAX = 15'd32767;

  typedef struct packed {
    logic        active;
    logic [1:0]  kind;
    logic [31:0] incr;
    logic [14:0] level;
    logic [31:0] phase;
  } voice_t;

endpackage

FILE: rtl/aob_cell.sv
// one voice slot of the rotating voice ring
// depends on aob_pkg
module aob_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            clear,
  input  aob_pkg::voice_t d,
  output aob_pkg::voice_t q
);

  logic active_r;
  logic [1:0] kind_r;
  logic [31:0] incr_r;
  logic [14:0] level_r;
  logic [31:0] phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (clear) begin
      active_r <= 1'b0;
    end else if (shift_en) begin
      active_r <= d.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      kind_r  <= d.kind;
      incr_r  <= d.incr;
      level_r <= d.level;
      phase_r <= d.phase;
    end
  end

  assign q = '{active: active_r, kind: kind_r, incr: incr_r, level: level_r, phase: phase_r};

endmodule

FILE: rtl/aob_voice_eval.sv
// pipelined voice evaluation (sine polynomial, scaling) and mix accumulator
// depends on aob_pkg
module aob_voice_eval #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SUM_W = 20,
  parameter int CNT_W = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clr,
  input  logic                    in_vld,
  input  aob_pkg::voice_t         vin,
  output logic signed [SUM_W-1:0] sum,
  output logic [CNT_W-1:0]        count,
  output logic                    busy
);

  localparam int POS_W = SINE_TABLE_BITS - 2;

  // stage 1
  logic        v1_r;
  logic [1:0]  quad1_r, kind1_r;
  logic [14:0] lvl1_r;
  logic [15:0] saw1_r;
  logic [16:0] x1_r;
  logic [15:0] x21_r;
  logic [16:0] x_base, x_nxt;
  logic [33:0] xx;

  assign x_base = {2'b00, vin.phase[29 -: POS_W], {(17 - SINE_TABLE_BITS){1'b0}}};
  assign x_nxt  = vin.phase[30] ? (aob_pkg::HALF_TURN - x_base) : x_base;
  assign xx     = x_nxt * x_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    quad1_r <= vin.phase[31:30];
    kind1_r <= vin.kind;
    lvl1_r  <= vin.level;
    saw1_r  <= vin.phase[31:16];
    x1_r    <= x_nxt;
    x21_r   <= xx[30:15];
  end

  // stage 2
  logic        v2_r;
  logic [1:0]  quad2_r, kind2_r;
  logic [14:0] lvl2_r;
  logic [15:0] saw2_r;
  logic [16:0] x2s_r;
  logic [15:0] x22_r;
  logic [14:0] t2_r;
  logic [27:0] p2;
  logic [14:0] t2_nxt;

  assign p2     = aob_pkg::POLY_C3 * x21_r;
  assign t2_nxt = aob_pkg::POLY_C2 - 15'(p2[27:15]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    quad2_r <= quad1_r;
    kind2_r <= kind1_r;
    lvl2_r  <= lvl1_r;
    saw2_r  <= saw1_r;
    x2s_r   <= x1_r;
    x22_r   <= x21_r;
    t2_r    <= t2_nxt;
  end

  // stage 3
  logic        v3_r;
  logic [1:0]  quad3_r, kind3_r;
  logic [14:0] lvl3_r;
  logic [15:0] saw3_r;
  logic [16:0] x3_r;
  logic [15:0] t3_r;
  logic [30:0] p3;
  logic [15:0] t3_nxt;

  assign p3     = t2_r * x22_r;
  assign t3_nxt = aob_pkg::POLY_C1 - p3[30:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    quad3_r <= quad2_r;
    kind3_r <= kind2_r;
    lvl3_r  <= lvl2_r;
    saw3_r  <= saw2_r;
    x3_r    <= x2s_r;
    t3_r    <= t3_nxt;
  end

  // stage 4: sine magnitude with clamp
  logic        v4_r;
  logic [1:0]  quad4_r, kind4_r;
  logic [14:0] lvl4_r;
  logic [15:0] saw4_r;
  logic [14:0] y4_r;
  logic [32:0] p4;
  logic [14:0] y4_nxt;

  assign p4     = t3_r * x3_r;
  assign y4_nxt = (p4[32:15] > 18'(aob_pkg::SINE_MAX)) ? aob_pkg::SINE_MAX : p4[29:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    quad4_r <= quad3_r;
    kind4_r <= kind3_r;
    lvl4_r  <= lvl3_r;
    saw4_r  <= saw3_r;
    y4_r    <= y4_nxt;
  end

  // stage 5: waveform select and level scaling
  logic        v5_r;
  logic        neg5_r;
  logic [15:0] val5_r;
  logic [15:0] mag5, saw_mag;
  logic [30:0] p5;
  logic        neg5_nxt;
  logic [15:0] val5_nxt;

  assign saw_mag = saw4_r[15] ? (16'd0 - saw4_r) : saw4_r;
  assign mag5    = (kind4_r == aob_pkg::WAVE_SAW) ? saw_mag : {1'b0, y4_r};
  assign p5      = mag5 * lvl4_r;

  always_comb begin
    case (kind4_r)
      aob_pkg::WAVE_SINE: begin
        neg5_nxt = quad4_r[1];
        val5_nxt = p5[30:15];
      end
      aob_pkg::WAVE_SQUARE: begin
        neg5_nxt = quad4_r[1] && (y4_r != 15'd0);
        val5_nxt = {1'b0, lvl4_r};
      end
      aob_pkg::WAVE_SAW: begin
        neg5_nxt = saw4_r[15];
        val5_nxt = p5[30:15];
      end
      default: begin
        neg5_nxt = 1'b0;
        val5_nxt = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    neg5_r <= neg5_nxt;
    val5_r <= val5_nxt;
  end

  // accumulator
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] count_r;
  logic signed [SUM_W-1:0] term;

  assign term = neg5_r ? -$signed(SUM_W'(val5_r)) : $signed(SUM_W'(val5_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (clr) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      if (v5_r) begin
        sum_r <= sum_r + term;
      end
      if (in_vld) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign sum   = sum_r;
  assign count = count_r;
  assign busy  = v1_r | v2_r | v3_r | v4_r | v5_r;

endmodule

FILE: rtl/aob_divider.sv
// restoring divider, one quotient bit per cycle
// no dependencies
module aob_divider #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [STEP_W-1:0] step_r;
  logic busy_r, done_r;
  logic [DEN_W:0] rem_sh;
  logic ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/additive_oscillator_bank.sv
// additive oscillator bank: ring of voice cells, evaluation pipeline, divider
// depends on aob_pkg, aob_cell, aob_voice_eval, aob_divider
// tick: ring pass over all voices, pipeline drain, one divide step per quotient bit;
//   no divide with no active voice; add: scan, then write if a slot is free and new;
//   remove: scan pass; clear: no pass; one request in flight, next accepted with result
// reset empties the voice table; no clearing pass is needed
module additive_oscillator_bank #(
  parameter int VOICES = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [1:0]         in_wave_kind,
  input  logic [31:0]        in_tuning_word,
  input  logic [14:0]        in_amplitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic [1:0]         out_status
);

  localparam int STEP_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MAG_W  = 15 + $clog2(VOICES);
  localparam int SUM_W  = MAG_W + 1;
  localparam int CNT_W  = $clog2(VOICES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WRITE = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r;
  logic [1:0]  req_r, kind_r;
  logic [31:0] word_r;
  logic [14:0] level_r;
  logic [STEP_W-1:0] step_r, free_step_r;
  logic dup_r, found_r, free_r;
  logic signed [15:0] res_sample_r;
  logic [1:0] res_status_r;
  logic out_valid_r;
  logic signed [15:0] out_sample_r;
  logic [1:0] out_status_r;

  aob_pkg::voice_t chain [VOICES];
  aob_pkg::voice_t tail, fb;
  logic shift_en, clear_all, accept, last_step, match;
  logic dup_nxt, found_nxt, free_nxt;
  logic [STEP_W-1:0] free_step_nxt;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign shift_en  = (state_r == S_SCAN) || (state_r == S_WRITE);
  assign clear_all = accept && (in_req_type == aob_pkg::REQ_CLEAR);
  assign tail      = chain[VOICES-1];
  assign last_step = (step_r == STEP_W'(VOICES - 1));
  assign match     = tail.active && (tail.incr == word_r);

  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    if (i == 0) begin : g_head
      aob_cell u_cell (.clk(clk), .rst_n(rst_n), .shift_en(shift_en), .clear(clear_all),
                       .d(fb), .q(chain[i]));
    end else begin : g_body
      aob_cell u_cell (.clk(clk), .rst_n(rst_n), .shift_en(shift_en), .clear(clear_all),
                       .d(chain[i-1]), .q(chain[i]));
    end
  end

  // feedback from the tail of the ring into the head
  always_comb begin
    fb            = tail;
    dup_nxt       = dup_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    free_step_nxt = free_step_r;
    if (state_r == S_SCAN) begin
      case (req_r)
        aob_pkg::REQ_TICK: begin
          if (tail.active) begin
            fb.phase = tail.phase + tail.incr;
          end
        end
        aob_pkg::REQ_ADD: begin
          if (match) begin
            dup_nxt = 1'b1;
          end
          // ring presents voices in descending slot order, so the last free one is lowest
          if (!tail.active) begin
            free_nxt      = 1'b1;
            free_step_nxt = step_r;
          end
        end
        aob_pkg::REQ_REMOVE: begin
          if (match) begin
            fb.active = 1'b0;
            found_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == S_WRITE && step_r == free_step_r) begin
      fb = '{active: 1'b1, kind: kind_r, incr: word_r, level: level_r, phase: 32'd0};
    end
  end

  logic eval_vld, eval_busy;
  logic signed [SUM_W-1:0] mix_sum;
  logic [CNT_W-1:0] mix_cnt;

  assign eval_vld = (state_r == S_SCAN) && (req_r == aob_pkg::REQ_TICK) && tail.active;

  aob_voice_eval #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_eval (
    .clk(clk),
    .rst_n(rst_n),
    .clr(accept),
    .in_vld(eval_vld),
    .vin(tail),
    .sum(mix_sum),
    .count(mix_cnt),
    .busy(eval_busy)
  );

  logic div_start, div_done;
  logic [MAG_W-1:0] sum_mag, quo;

  assign sum_mag   = mix_sum[SUM_W-1] ? MAG_W'(-mix_sum) : MAG_W'(mix_sum);
  assign div_start = (state_r == S_DRAIN) && !eval_busy && (mix_cnt != '0);

  aob_divider #(
    .NUM_W(MAG_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .num(sum_mag),
    .den(mix_cnt),
    .done(div_done),
    .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= (in_req_type == aob_pkg::REQ_CLEAR) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_step) begin
            case (req_r)
              aob_pkg::REQ_TICK: state_r <= S_DRAIN;
              aob_pkg::REQ_ADD:  state_r <= (dup_nxt || !free_nxt) ? S_FIN : S_WRITE;
              default:           state_r <= S_FIN;
            endcase
          end
        end
        S_WRITE: begin
          if (last_step) begin
            state_r <= S_FIN;
          end
        end
        S_DRAIN: begin
          if (!eval_busy) begin
            state_r <= (mix_cnt != '0) ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r        <= in_req_type;
      kind_r       <= in_wave_kind;
      word_r       <= in_tuning_word;
      level_r      <= in_amplitude;
      step_r       <= '0;
      dup_r        <= 1'b0;
      found_r      <= 1'b0;
      free_r       <= 1'b0;
      free_step_r  <= '0;
      res_sample_r <= '0;
      res_status_r <= aob_pkg::STAT_DONE;
    end else begin
      if (shift_en) begin
        step_r <= last_step ? '0 : step_r + 1'b1;
      end
      if (state_r == S_SCAN) begin
        dup_r       <= dup_nxt;
        found_r     <= found_nxt;
        free_r      <= free_nxt;
        free_step_r <= free_step_nxt;
        if (last_step) begin
          if (req_r == aob_pkg::REQ_ADD) begin
            res_status_r <= dup_nxt ? aob_pkg::STAT_DUP
                          : (!free_nxt ? aob_pkg::STAT_FULL : aob_pkg::STAT_DONE);
          end else if (req_r == aob_pkg::REQ_REMOVE && !found_nxt) begin
            res_status_r <= aob_pkg::STAT_MISSING;
          end
        end
      end
      if (state_r == S_DIV && div_done) begin
        res_sample_r <= mix_sum[SUM_W-1] ? -$signed(16'(quo)) : $signed(16'(quo));
      end
    end
    if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
      out_sample_r <= res_sample_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_status = out_status_r;

endmodule
